/* rtl/tod_pkg.sv */
package tod_pkg;

    localparam int TICK_W = 32;
    localparam int DIV_CNT_W = $clog2(TICK_W);
    localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(TICK_W - 1);

    localparam int SECS_W = 12;
    localparam logic [SECS_W-1:0] LONG_GAP_SECONDS = 12'd3600;

    localparam logic [4:0] HOUR_LAST = 5'd23;
    localparam logic [5:0] MINUTE_LAST = 6'd59;
    localparam logic [5:0] SECOND_LAST = 6'd59;
    localparam logic [7:0] MINUTE_SAT = 8'd255;

    localparam logic [7:0] FPS_RESET = 8'd60;
    localparam logic [7:0] RESYNC_RESET = 8'd30;

    localparam logic REG_FRAMES_PER_SECOND = 1'b0;
    localparam logic REG_RESYNC_AFTER_MINUTES = 1'b1;

    localparam logic MODE_ADVANCE = 1'b0;
    localparam logic MODE_SYNC = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [TICK_W-1:0] now_ticks;
        logic [4:0]        set_hours;
        logic [5:0]        set_minutes;
        logic [5:0]        set_seconds;
        logic              set_valid;
    } tod_in_t;

    typedef struct packed {
        logic       minute_changed;
        logic       resync_due;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       clock_valid;
    } tod_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/tod_div.sv */
module tod_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [tod_pkg::TICK_W-1:0]  dividend,
    input  logic [7:0]                  divisor,
    output tod_pkg::div_stat_t          stat,
    output logic [tod_pkg::TICK_W-1:0]  quotient,
    output logic [7:0]                  remainder
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [tod_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [tod_pkg::TICK_W-1:0]      quo_reg;
    logic [tod_pkg::TICK_W-1:0]      quo_next;
    logic [7:0]                      rem_reg;
    logic [7:0]                      rem_next;
    logic [7:0]                      dvs_reg;
    logic [8:0]                      trial;
    logic                            qbit;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {rem_reg, quo_reg[tod_pkg::TICK_W-1]};
        qbit = (trial >= {1'b0, dvs_reg});
        rem_next = qbit ? 8'(trial - {1'b0, dvs_reg}) : trial[7:0];
        quo_next = {quo_reg[tod_pkg::TICK_W-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == tod_pkg::DIV_CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient = quo_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/tick_driven_time_of_day_unit.sv */
// A sync word, or an advance on an invalid clock or wrapped counter, goes from acceptance
// straight to the result; a dividing advance runs the bit-serial divide and then steps
// the seconds (0..3600 of them) one at a time before the result.
// One word in flight; s_ready is high only while the sequencer is idle, so a new word
// is taken only once the last one has left ST_FIN; the one-second step loop is the longest part.
// Reset (aresetn low, synchronous): time invalid, counters and baseline zero,
// frames_per_second 60, resync_after_minutes 30, no result pending.
module tick_driven_time_of_day_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tod_pkg::tod_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tod_pkg::tod_out_t  m_data,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_wdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_STEP = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [tod_pkg::TICK_W-1:0]  baseline_reg, baseline_next;
    logic [tod_pkg::TICK_W-1:0]  now_reg, now_next;
    logic [7:0]                  mss_reg, mss_next;
    logic [4:0]                  hr_reg, hr_next;
    logic [5:0]                  min_reg, min_next;
    logic [5:0]                  sec_reg, sec_next;
    logic                        valid_reg, valid_next;
    logic [tod_pkg::SECS_W-1:0]  secs_reg, secs_next;
    logic                        changed_reg, changed_next;
    logic [7:0]                  fps_reg;
    logic [7:0]                  resync_reg;
    logic                        m_valid_reg, m_valid_next;
    tod_pkg::tod_out_t           m_data_reg, m_data_next;

    logic                        s_fire;
    logic [tod_pkg::TICK_W:0]    diff;
    logic [7:0]                  rate;
    logic                        div_start;
    tod_pkg::div_stat_t          div_stat;
    logic [tod_pkg::TICK_W-1:0]  div_quo;
    logic [7:0]                  div_rem;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire = s_valid && s_ready;
    assign rate = (fps_reg == 8'd0) ? 8'd1 : fps_reg;
    assign diff = {1'b0, s_data.now_ticks} - {1'b0, baseline_reg};

    tod_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (diff[tod_pkg::TICK_W-1:0]),
        .divisor   (rate),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        state_next = state_reg;
        baseline_next = baseline_reg;
        now_next = now_reg;
        mss_next = mss_reg;
        hr_next = hr_reg;
        min_next = min_reg;
        sec_next = sec_reg;
        valid_next = valid_reg;
        secs_next = secs_reg;
        changed_next = changed_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next = m_data_reg;
        div_start = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    changed_next = 1'b0;
                    now_next = s_data.now_ticks;
                    state_next = ST_FIN;
                    if (s_data.mode == tod_pkg::MODE_SYNC) begin
                        hr_next = (s_data.set_hours > tod_pkg::HOUR_LAST) ?
                                  tod_pkg::HOUR_LAST : s_data.set_hours;
                        min_next = (s_data.set_minutes > tod_pkg::MINUTE_LAST) ?
                                   tod_pkg::MINUTE_LAST : s_data.set_minutes;
                        sec_next = (s_data.set_seconds > tod_pkg::SECOND_LAST) ?
                                   tod_pkg::SECOND_LAST : s_data.set_seconds;
                        valid_next = s_data.set_valid;
                        baseline_next = s_data.now_ticks;
                        mss_next = '0;
                    end else if (valid_reg) begin
                        if (diff[tod_pkg::TICK_W]) begin
                            // counter wrapped: rebase only
                            baseline_next = s_data.now_ticks;
                        end else begin
                            div_start = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    if (div_quo == '0) begin
                        state_next = ST_FIN;
                    end else if (div_quo > tod_pkg::TICK_W'(tod_pkg::LONG_GAP_SECONDS)) begin
                        mss_next = resync_reg;
                        changed_next = 1'b1;
                        state_next = ST_FIN;
                    end else begin
                        // keep the leftover ticks: baseline + secs*rate == now - remainder
                        baseline_next = now_reg - tod_pkg::TICK_W'(div_rem);
                        secs_next = div_quo[tod_pkg::SECS_W-1:0];
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP: begin
                // advance one second per cycle
                secs_next = secs_reg - 1'b1;
                if (sec_reg == tod_pkg::SECOND_LAST) begin
                    sec_next = '0;
                    changed_next = 1'b1;
                    if (mss_reg != tod_pkg::MINUTE_SAT) begin
                        mss_next = mss_reg + 1'b1;
                    end
                    if (min_reg == tod_pkg::MINUTE_LAST) begin
                        min_next = '0;
                        if (hr_reg == tod_pkg::HOUR_LAST) begin
                            hr_next = '0;
                            mss_next = resync_reg;
                        end else begin
                            hr_next = hr_reg + 1'b1;
                        end
                    end else begin
                        min_next = min_reg + 1'b1;
                    end
                end else begin
                    sec_next = sec_reg + 1'b1;
                end
                if (secs_reg == tod_pkg::SECS_W'(1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next.minute_changed = changed_reg;
                    m_data_next.resync_due = (mss_reg >= resync_reg);
                    m_data_next.hours = hr_reg;
                    m_data_next.minutes = min_reg;
                    m_data_next.seconds = sec_reg;
                    m_data_next.clock_valid = valid_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            baseline_reg <= '0;
            mss_reg <= '0;
            hr_reg <= '0;
            min_reg <= '0;
            sec_reg <= '0;
            valid_reg <= 1'b0;
            fps_reg <= tod_pkg::FPS_RESET;
            resync_reg <= tod_pkg::RESYNC_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            baseline_reg <= baseline_next;
            mss_reg <= mss_next;
            hr_reg <= hr_next;
            min_reg <= min_next;
            sec_reg <= sec_next;
            valid_reg <= valid_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    tod_pkg::REG_FRAMES_PER_SECOND: fps_reg <= cfg_wdata;
                    tod_pkg::REG_RESYNC_AFTER_MINUTES: resync_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        now_reg <= now_next;
        secs_reg <= secs_next;
        changed_reg <= changed_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

endmodule

/* rtl/tod_checker.sv */
module tod_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input tod_pkg::tod_out_t  m_data
);

    // one word at a time: the input side closes right after a word is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a word is in flight");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result word changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.hours <= tod_pkg::HOUR_LAST) &&
                    (m_data.minutes <= tod_pkg::MINUTE_LAST) &&
                    (m_data.seconds <= tod_pkg::SECOND_LAST))
        else $error("time of day out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.clock_valid |-> !m_data.minute_changed)
        else $error("minute change reported on an invalid clock");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset left a result pending or the input closed");

endmodule

bind tick_driven_time_of_day_unit tod_checker u_tod_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* tb/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 8000;

    // Tracks the clock state the block should hold and the results it owes.
    class tod_scoreboard;
        tod_pkg::tod_out_t          expected_q[$];
        int                         mismatches;
        int                         results_seen;
        logic [7:0]                 fps_reg;
        logic [7:0]                 resync_reg;
        logic [tod_pkg::TICK_W-1:0] base_ticks;
        logic [7:0]                 since_sync;
        logic [4:0]                 hh;
        logic [5:0]                 mm;
        logic [5:0]                 ss;
        logic                       time_ok;

        function new();
            fps_reg      = tod_pkg::FPS_RESET;
            resync_reg   = tod_pkg::RESYNC_RESET;
            base_ticks   = '0;
            since_sync   = '0;
            hh           = '0;
            mm           = '0;
            ss           = '0;
            time_ok      = 1'b0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_reg(logic idx, logic [7:0] value);
            if (idx == tod_pkg::REG_FRAMES_PER_SECOND) begin
                fps_reg = value;
            end else begin
                resync_reg = value;
            end
        endfunction

        function void note_word(tod_pkg::tod_in_t w);
            tod_pkg::tod_out_t          want;
            logic [tod_pkg::TICK_W-1:0] rate;
            logic [tod_pkg::TICK_W-1:0] elapsed;
            longint unsigned            secs;
            logic                       changed;
            int                         n;
            changed = 1'b0;
            if (w.mode == tod_pkg::MODE_SYNC) begin
                hh         = (w.set_hours > tod_pkg::HOUR_LAST) ?
                             tod_pkg::HOUR_LAST : w.set_hours;
                mm         = (w.set_minutes > tod_pkg::MINUTE_LAST) ?
                             tod_pkg::MINUTE_LAST : w.set_minutes;
                ss         = (w.set_seconds > tod_pkg::SECOND_LAST) ?
                             tod_pkg::SECOND_LAST : w.set_seconds;
                time_ok    = w.set_valid;
                base_ticks = w.now_ticks;
                since_sync = '0;
            end else if (time_ok) begin
                if (w.now_ticks < base_ticks) begin
                    // counter wrapped: rebase, keep the time
                    base_ticks = w.now_ticks;
                end else begin
                    rate    = (fps_reg == 8'd0) ? tod_pkg::TICK_W'(1) :
                              tod_pkg::TICK_W'(fps_reg);
                    elapsed = w.now_ticks - base_ticks;
                    secs    = elapsed / rate;
                    if (secs > tod_pkg::LONG_GAP_SECONDS) begin
                        since_sync = resync_reg;
                        changed    = 1'b1;
                    end else if (secs != 0) begin
                        // move the baseline by whole seconds only, leftover ticks carry
                        base_ticks = base_ticks + tod_pkg::TICK_W'(secs) * rate;
                        for (n = 0; n < int'(secs); n++) begin
                            if (ss == tod_pkg::SECOND_LAST) begin
                                ss      = '0;
                                changed = 1'b1;
                                if (since_sync != tod_pkg::MINUTE_SAT) begin
                                    since_sync++;
                                end
                                if (mm == tod_pkg::MINUTE_LAST) begin
                                    mm = '0;
                                    if (hh == tod_pkg::HOUR_LAST) begin
                                        hh         = '0;
                                        since_sync = resync_reg;
                                    end else begin
                                        hh++;
                                    end
                                end else begin
                                    mm++;
                                end
                            end else begin
                                ss++;
                            end
                        end
                    end
                end
            end
            want.minute_changed = changed;
            want.resync_due     = (since_sync >= resync_reg);
            want.hours          = hh;
            want.minutes        = mm;
            want.seconds        = ss;
            want.clock_valid    = time_ok;
            expected_q.push_back(want);
        endfunction

        function string show(tod_pkg::tod_out_t r);
            return $sformatf("%0d:%0d:%0d mc=%0b due=%0b valid=%0b", r.hours, r.minutes,
                             r.seconds, r.minute_changed, r.resync_due, r.clock_valid);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_result(tod_pkg::tod_out_t got);
            tod_pkg::tod_out_t want;
            string             bad;
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result %0d with no word outstanding: %s",
                                          results_seen, show(got)));
            end else begin
                want = expected_q.pop_front();
                bad  = "";
                if (got.minute_changed !== want.minute_changed) bad = {bad, " minute_changed"};
                if (got.resync_due !== want.resync_due) bad = {bad, " resync_due"};
                if (got.hours !== want.hours) bad = {bad, " hours"};
                if (got.minutes !== want.minutes) bad = {bad, " minutes"};
                if (got.seconds !== want.seconds) bad = {bad, " seconds"};
                if (got.clock_valid !== want.clock_valid) bad = {bad, " clock_valid"};
                if (bad != "") begin
                    report_mismatch($sformatf("result %0d wrong%s: got %s, expected %s",
                                              results_seen, bad, show(got), show(want)));
                end
            end
        endtask
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    tod_pkg::tod_in_t           s_data;
    logic                       m_valid;
    logic                       m_ready;
    tod_pkg::tod_out_t          m_data;
    logic                       cfg_wr_en;
    logic                       cfg_index;
    logic [7:0]                 cfg_wdata;

    tod_scoreboard              board;
    int                         send_idle_pct = 34;
    int                         recv_idle_pct = 76;
    int                         hold_reqs = 0;
    int                         stalls_done = 0;
    logic [tod_pkg::TICK_W-1:0] tick_cursor;
    logic [7:0]                 cur_fps;
    int                         words_sent;
    int                         sync_words;

    tick_driven_time_of_day_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic tod_pkg::tod_in_t sync_word(logic [4:0] h, logic [5:0] m,
                                                   logic [5:0] s, logic v,
                                                   logic [tod_pkg::TICK_W-1:0] now);
        tod_pkg::tod_in_t w;
        w.mode        = tod_pkg::MODE_SYNC;
        w.now_ticks   = now;
        w.set_hours   = h;
        w.set_minutes = m;
        w.set_seconds = s;
        w.set_valid   = v;
        return w;
    endfunction

    // set fields carry noise; the block must ignore them on advance
    function automatic tod_pkg::tod_in_t advance_word(logic [tod_pkg::TICK_W-1:0] now);
        tod_pkg::tod_in_t w;
        w.mode        = tod_pkg::MODE_ADVANCE;
        w.now_ticks   = now;
        w.set_hours   = 5'($urandom);
        w.set_minutes = 6'($urandom);
        w.set_seconds = 6'($urandom);
        w.set_valid   = 1'($urandom);
        return w;
    endfunction

    // entered and left at a falling edge
    task automatic send_word(input tod_pkg::tod_in_t w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_word(w);
        words_sent++;
        if (w.mode == tod_pkg::MODE_SYNC) sync_words++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (board.expected_q.size() != 0) @(negedge aclk);
    endtask

    task automatic set_config(logic [7:0] fps, logic [7:0] thr);
        cfg_wr_en <= 1'b1;
        cfg_index <= tod_pkg::REG_FRAMES_PER_SECOND;
        cfg_wdata <= fps;
        @(negedge aclk);
        cfg_index <= tod_pkg::REG_RESYNC_AFTER_MINUTES;
        cfg_wdata <= thr;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        board.set_reg(tod_pkg::REG_FRAMES_PER_SECOND, fps);
        board.set_reg(tod_pkg::REG_RESYNC_AFTER_MINUTES, thr);
        cur_fps = fps;
    endtask

    // Mostly a sync followed by advances over a rising tick count; some wraps and noise.
    task automatic run_random(int count, int hold_after);
        logic [tod_pkg::TICK_W-1:0] rate;
        logic [tod_pkg::TICK_W-1:0] now;
        tod_pkg::tod_in_t           w;
        int                         roll;
        int                         pick;
        int                         secs;
        int                         done;
        logic                       held;
        rate = (cur_fps == 8'd0) ? tod_pkg::TICK_W'(1) : tod_pkg::TICK_W'(cur_fps);
        done = 0;
        held = 1'b0;
        while (done < count) begin
            roll = $urandom_range(0, 99);
            if (done == 0 || roll < 12) begin
                now = ($urandom_range(0, 1) == 0) ? tod_pkg::TICK_W'($urandom) : tick_cursor;
                if ($urandom_range(0, 9) == 0) begin
                    w = sync_word(5'($urandom), 6'($urandom), 6'($urandom), 1'($urandom), now);
                end else begin
                    w = sync_word(($urandom_range(0, 3) == 0) ? 5'd23 : 5'($urandom_range(0, 23)),
                                  ($urandom_range(0, 2) == 0) ? 6'd59 : 6'($urandom_range(0, 59)),
                                  6'($urandom_range(0, 59)), 1'b1, now);
                end
            end else begin
                if (roll < 16) begin
                    now = tod_pkg::TICK_W'($urandom);
                end else if (roll < 20) begin
                    now = tick_cursor - tod_pkg::TICK_W'($urandom_range(1, 5000));
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45) secs = $urandom_range(0, 3);
                    else if (pick < 80) secs = $urandom_range(4, 150);
                    else if (pick < 92) secs = $urandom_range(151, 3600);
                    else if (pick < 97) secs = $urandom_range(3601, 5000);
                    else secs = $urandom_range(65530, 65540);
                    now = tick_cursor + tod_pkg::TICK_W'(secs) * rate
                          + tod_pkg::TICK_W'($urandom_range(0, rate - 1));
                end
                w = advance_word(now);
            end
            // advances on an invalid clock do nothing, so they do not count
            if (w.mode == tod_pkg::MODE_SYNC || board.time_ok) done++;
            tick_cursor = now;
            send_word(w);
            if (done == hold_after && !held) begin
                held = 1'b1;
                hold_reqs++;
            end
        end
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_reqs != stalls_done) begin
                // long stall so the block fills and backs up its input
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                stalls_done++;
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result(m_data);
        end
    end

    initial begin
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = tod_pkg::REG_FRAMES_PER_SECOND;
        cfg_wdata   = '0;
        aresetn     = 1'b0;
        tick_cursor = '0;
        cur_fps     = tod_pkg::FPS_RESET;
        words_sent  = 0;
        sync_words  = 0;
        board       = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: invalid clock, clamping, midnight, wrap, long gaps
        send_word(advance_word(32'd1000));
        send_word(sync_word(5'd31, 6'd63, 6'd63, 1'b0, 32'd0));
        send_word(advance_word(32'd100000));
        send_word(sync_word(5'd23, 6'd59, 6'd58, 1'b1, 32'd0));
        send_word(advance_word(32'd59));
        send_word(advance_word(32'd180));
        send_word(sync_word(5'd0, 6'd0, 6'd0, 1'b1, 32'hFFFF_FFF0));
        send_word(advance_word(32'hFFFF_FFFF));
        send_word(advance_word(32'd5));
        send_word(advance_word(32'd5 + 32'd3601 * 32'd60));
        send_word(advance_word(32'd5 + 32'd3600 * 32'd60));
        send_word(advance_word(32'd5 + 32'd3600 * 32'd60 + 32'd65537 * 32'd60));
        send_word(advance_word(32'd5 + 32'd3600 * 32'd60 + 32'd4106 * 32'd60));

        // slowest rate, top threshold: drive minutes since sync into saturation
        drain_results();
        set_config(8'd1, 8'd255);
        send_word(sync_word(5'd0, 6'd0, 6'd0, 1'b1, 32'd0));
        send_word(advance_word(32'd3600));
        send_word(advance_word(32'd7200));
        send_word(advance_word(32'd10800));
        send_word(advance_word(32'd14400));
        send_word(advance_word(32'd18000));

        // zero rate acts as one, zero threshold keeps resync due
        drain_results();
        set_config(8'd0, 8'd0);
        send_word(sync_word(5'd12, 6'd34, 6'd56, 1'b1, 32'd100));
        send_word(advance_word(32'd110));

        // fastest rate: leftover ticks carry into the next word
        drain_results();
        set_config(8'd255, 8'd1);
        send_word(sync_word(5'd0, 6'd0, 6'd59, 1'b1, 32'd1000));
        send_word(advance_word(32'd1000 + 32'd255 * 32'd61 + 32'd254));
        send_word(advance_word(32'd1000 + 32'd255 * 32'd62));

        drain_results();
        set_config(tod_pkg::FPS_RESET, tod_pkg::RESYNC_RESET);
        run_random(39, -1);

        drain_results();
        send_idle_pct = 76;
        recv_idle_pct = 34;
        set_config(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
        run_random(39, -1);

        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(8'd25, 8'd3);
        run_random(38, 20);

        drain_results();
        repeat (40) @(posedge aclk);
        $display("summary: %0d words in (%0d syncs), %0d results checked, %0d long stalls",
                 words_sent, sync_words, board.results_seen, stalls_done);
        $display("summary: rates 0/1/25/60/255 and random, thresholds 0..255, %0d mismatches",
                 board.mismatches);
        if (board.mismatches == 0 && board.expected_q.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("timeout with %0d results outstanding", board.expected_q.size());
        $display("testbench: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tod_pkg.sv
rtl/tod_div.sv
rtl/tick_driven_time_of_day_unit.sv
rtl/tod_checker.sv
tb/testbench.sv
